// ===== hw/rtl/spectrum_display_smoother_top_assert.svh =====
// assertion macros for the spectrum display smoother
`ifndef SPECTRUM_DISPLAY_SMOOTHER_TOP_ASSERT_SVH
`define SPECTRUM_DISPLAY_SMOOTHER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// condition implies property in the same cycle
`define SDS_ASSERT_NOW(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error("sds assertion failed");

// condition implies property in the next cycle
`define SDS_ASSERT_NEXT(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
        else $error("sds assertion failed");

`else

`define SDS_ASSERT_NOW(lbl, ck, rn, a, b)
`define SDS_ASSERT_NEXT(lbl, ck, rn, a, b)

`endif

`endif

// ===== hw/rtl/sds_pkg.sv =====
// constants, types and helpers of the spectrum display smoother
package sds_pkg;

    localparam int BINS     = 4096;
    localparam int SPAN_MAX = 32;
    localparam int ADDR_W   = $clog2(BINS);
    localparam int CNT_W    = $clog2(BINS + 1);
    localparam int DIV_W    = 34;
    localparam int DCNT_W   = $clog2(DIV_W);
    localparam int LOG_ITER = 16;

    localparam logic signed [15:0] FLOOR_DB    = -16'sd25600;
    localparam logic signed [16:0] HEADROOM_DB = 17'sd1536;
    localparam logic [18:0] DB_PER_OCTAVE_Q16  = 19'd394566;
    localparam logic [31:0] STEP_UP_Q32        = 32'd11644838;
    localparam logic [31:0] STEP_DOWN_Q32      = 32'd11613351;

    localparam logic [12:0] RST_BINS   = 13'd4096;
    localparam logic [15:0] RST_MIN_DB = 16'hB000;
    localparam logic [15:0] RST_MAX_DB = 16'h0000;
    localparam logic [15:0] RST_WEIGHT = 16'd9830;

    typedef enum logic [1:0] {
        REG_BINS   = 2'd0,
        REG_MIN_DB = 2'd1,
        REG_MAX_DB = 2'd2,
        REG_WEIGHT = 2'd3
    } reg_idx_t;

    // saturate a wide signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v < -36'sd32768)
            r = -16'sd32768;
        else if (v > 36'sd32767)
            r = 16'sd32767;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/spectrum_display_smoother_top.sv =====
// spectrum display smoother: dB conversion, frame mapping, peak window and blend
//
// Each input transfer either loads one linear bin magnitude (req_type 0) or asks
// for the next smoothed bin (req_type 1). A load runs through the log2 unit,
// which squares the normalized mantissa once per cycle for 16
// fraction bits and then scales by 20*log10(2). The load that completes a
// frame starts the frame pass, during which no transfer is taken. The pass
// first maps every bin in place in the level memory through the
// 34-step shift-subtract divider (one cycle per bin when the whole frame
// sits at the floor). It then walks the bins again: for each bin the peak
// window of n entries (1 to 32) is read from the level memory and compared
// entry by entry, and the blend with the smoothed memory follows as a
// multiply and a write-back. A read request is served once the output
// register is free and waits there otherwise; loads keep being taken while a
// result waits. The smoothed memory needs no clearing pass: a fill mark holds
// how many leading entries have been written, and entries past it read as
// -100 dB. Configuration registers sit at byte addresses 0, 4, 8 and 12.
`include "spectrum_display_smoother_top_assert.svh"

module spectrum_display_smoother_top
    import sds_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // request channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic [31:0]              magnitude,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [15:0]       display_db,
    output logic [ADDR_W-1:0]        bin_index,
    output logic                     last_bin
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOG_SQ,
        ST_LOG_MUL,
        ST_LOG_END,
        ST_MAP_RD,
        ST_MAP_MUL,
        ST_MAP_PREP,
        ST_MAP_DIV,
        ST_MAP_WR,
        ST_MAP_FLAT,
        ST_WIN_MUL,
        ST_WIN_BOUND,
        ST_WIN_RD,
        ST_WIN_CMP,
        ST_BLD_MUL,
        ST_BLD_WR,
        ST_RD_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [12:0]        bins_reg;
    logic signed [15:0] min_db_reg;
    logic signed [15:0] max_db_reg;
    logic [15:0]        weight_reg;

    // block state
    logic signed [15:0] peak_reg;
    logic [CNT_W-1:0]   load_ptr_reg;
    logic [ADDR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;

    // log2 unit
    logic [31:0]        y_reg;
    logic [4:0]         p_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         k_reg;
    logic               mag_zero_reg;
    logic signed [40:0] db_prod_reg;

    // frame pass
    logic [CNT_W-1:0]   i_reg;
    logic [15:0]        den_reg;
    logic signed [33:0] num_reg;
    logic [DIV_W-1:0]   dvd_reg;
    logic [15:0]        rem_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   up_reg;
    logic [CNT_W-1:0]   down_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [CNT_W-1:0]   jlast_reg;
    logic               first_reg;
    logic signed [15:0] best_reg;
    logic signed [15:0] prev_reg;
    logic signed [33:0] bprod_reg;

    // read path
    logic [ADDR_W-1:0]  rd_idx_reg;
    logic               out_valid_reg;
    logic signed [15:0] display_db_reg;
    logic [ADDR_W-1:0]  bin_index_reg;
    logic               last_bin_reg;

    // memories
    logic [15:0]        level_mem [BINS];
    logic [15:0]        smooth_mem [BINS];
    logic [15:0]        lvl_rd_reg;
    logic [15:0]        sm_rd_reg;
    logic               lvl_we, lvl_re, sm_we, sm_re;
    logic [ADDR_W-1:0]  lvl_wa, lvl_ra, sm_wa, sm_ra;
    logic [15:0]        lvl_wd, sm_wd;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_BINS:   prdata = {19'b0, bins_reg};
            REG_MIN_DB: prdata = {16'b0, min_db_reg};
            REG_MAX_DB: prdata = {16'b0, max_db_reg};
            REG_WEIGHT: prdata = {16'b0, weight_reg};
            default:    prdata = 32'b0;
        endcase
    end

    // bin count clamped to the supported range
    logic [CNT_W-1:0] nb;
    always_comb
    begin
        if (bins_reg < 13'd2)
            nb = CNT_W'(2);
        else if (CNT_W'(bins_reg) > CNT_W'(BINS))
            nb = CNT_W'(BINS);
        else
            nb = CNT_W'(bins_reg);
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic in_xfer, out_xfer, out_free;
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid & in_ready;
    assign out_xfer   = out_valid_reg & out_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign display_db = display_db_reg;
    assign bin_index  = bin_index_reg;
    assign last_bin   = last_bin_reg;

    // read pointer wraps when the bin count shrank below it
    logic [ADDR_W-1:0] rptr_eff;
    logic [CNT_W-1:0]  rptr_inc;
    assign rptr_eff = (CNT_W'(rd_ptr_reg) >= nb) ? '0 : rd_ptr_reg;
    assign rptr_inc = CNT_W'(rptr_eff) + CNT_W'(1);

    // ------------------------------------------------------------------
    // log2 datapath
    // ------------------------------------------------------------------
    logic [4:0] msb_pos;
    always_comb
    begin
        msb_pos = 5'd0;
        for (int b = 0; b < 32; b++)
        begin
            if (magnitude[b])
                msb_pos = 5'(b);
        end
    end

    logic [63:0] sq;
    logic [32:0] sq_t;
    assign sq   = {32'b0, y_reg} * {32'b0, y_reg};
    assign sq_t = sq[63:31];

    logic signed [20:0] lg;
    assign lg = $signed({~p_reg[4], p_reg[3:0], frac_reg});

    logic [40:0]        prod_mag;
    logic [40:0]        prod_rnd;
    logic signed [17:0] db_w;
    logic signed [15:0] db_val;
    always_comb
    begin
        prod_mag = db_prod_reg[40] ? 41'(-db_prod_reg) : 41'(db_prod_reg);
        prod_rnd = prod_mag + (41'd1 << 23);
        db_w     = db_prod_reg[40] ? -$signed({1'b0, prod_rnd[40:24]})
                                   : $signed({1'b0, prod_rnd[40:24]});
        if (mag_zero_reg || db_w < 18'(FLOOR_DB))
            db_val = FLOOR_DB;
        else if (db_w > 18'sd32767)
            db_val = 16'sd32767;
        else
            db_val = db_w[15:0];
    end

    // peak and mapping range for the frame that this load may close
    logic signed [15:0] peak_new;
    logic signed [16:0] hi_mx, hi_val;
    logic [16:0]        den_w;
    logic [CNT_W-1:0]   load_inc;
    assign peak_new = (db_val > peak_reg) ? db_val : peak_reg;
    assign hi_mx    = 17'(max_db_reg) - HEADROOM_DB;
    assign hi_val   = (hi_mx > 17'(peak_new)) ? hi_mx : 17'(peak_new);
    assign den_w    = 17'(hi_val - 17'(FLOOR_DB));
    assign load_inc = load_ptr_reg + CNT_W'(1);

    // ------------------------------------------------------------------
    // mapping datapath
    // ------------------------------------------------------------------
    logic signed [16:0] span_w, off_w;
    assign span_w = 17'(max_db_reg) - 17'(min_db_reg);
    assign off_w  = 17'($signed(lvl_rd_reg)) - 17'(FLOOR_DB);

    logic [DIV_W-1:0] num_mag;
    assign num_mag = num_reg[33] ? DIV_W'(-num_reg) : DIV_W'(num_reg);

    logic [16:0] div_r;
    logic        div_ge;
    assign div_r  = {rem_reg, dvd_reg[DIV_W-1]};
    assign div_ge = (div_r >= {1'b0, den_reg});

    logic signed [35:0] q_s;
    logic signed [15:0] map_val;
    assign q_s     = neg_reg ? -$signed({2'b0, dvd_reg}) : $signed({2'b0, dvd_reg});
    assign map_val = sat16(36'(min_db_reg) + q_s);

    logic [CNT_W-1:0] i_inc;
    assign i_inc = i_reg + CNT_W'(1);

    // ------------------------------------------------------------------
    // window datapath
    // ------------------------------------------------------------------
    logic [CNT_W+31:0] up_p, down_p;
    assign up_p   = (CNT_W+32)'(i_reg) * (CNT_W+32)'(STEP_UP_Q32);
    assign down_p = (CNT_W+32)'(i_reg) * (CNT_W+32)'(STEP_DOWN_Q32)
                  + (CNT_W+32)'(32'hFFFF_FFFF);

    logic [CNT_W:0] w_i1, w_i2a, w_i2b, w_lim, w_i2, w_nbm1;
    logic [CNT_W-1:0] w_jlast;
    always_comb
    begin
        w_i1   = (CNT_W+1)'(i_reg - down_reg);
        w_i2a  = (CNT_W+1)'(up_reg) + (CNT_W+1)'(1);
        w_nbm1 = (CNT_W+1)'(nb) - (CNT_W+1)'(1);
        w_i2b  = (w_i2a > w_nbm1) ? w_nbm1 : w_i2a;
        w_lim  = w_i1 + (CNT_W+1)'(SPAN_MAX);
        w_i2   = (w_i2b > w_lim) ? w_lim : w_i2b;
        if (w_i2 > w_i1 + (CNT_W+1)'(1))
            w_jlast = CNT_W'(w_i2 - (CNT_W+1)'(1));
        else
            w_jlast = CNT_W'(w_i1);
    end

    logic signed [15:0] win_val;
    assign win_val = $signed(lvl_rd_reg);

    // ------------------------------------------------------------------
    // blend datapath
    // ------------------------------------------------------------------
    logic signed [15:0] prev_w;
    logic signed [16:0] diff_w;
    assign prev_w = (i_reg < fill_reg) ? $signed(sm_rd_reg) : FLOOR_DB;
    assign diff_w = 17'(best_reg) - 17'(prev_w);

    logic [33:0]        bmag;
    logic [33:0]        brnd;
    logic signed [18:0] bdelta;
    logic signed [15:0] blend_val;
    always_comb
    begin
        bmag      = bprod_reg[33] ? 34'(-bprod_reg) : 34'(bprod_reg);
        brnd      = bmag + 34'd32768;
        bdelta    = bprod_reg[33] ? -$signed({1'b0, brnd[33:16]})
                                  : $signed({1'b0, brnd[33:16]});
        blend_val = sat16(36'(prev_reg) + 36'(bdelta));
    end

    // ------------------------------------------------------------------
    // memory port control
    // ------------------------------------------------------------------
    always_comb
    begin
        lvl_we = 1'b0;
        lvl_wa = load_ptr_reg[ADDR_W-1:0];
        lvl_wd = db_val;
        lvl_re = 1'b0;
        lvl_ra = i_reg[ADDR_W-1:0];
        sm_we  = 1'b0;
        sm_wa  = i_reg[ADDR_W-1:0];
        sm_wd  = blend_val;
        sm_re  = 1'b0;
        sm_ra  = i_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                // read request fetches the smoothed entry right away
                sm_re = in_xfer && req_type;
                sm_ra = rptr_eff;
            end
            ST_LOG_END:
            begin
                lvl_we = (load_ptr_reg < CNT_W'(BINS));
            end
            ST_MAP_RD:
            begin
                lvl_re = 1'b1;
            end
            ST_MAP_WR:
            begin
                lvl_we = 1'b1;
                lvl_wa = i_reg[ADDR_W-1:0];
                lvl_wd = map_val;
            end
            ST_MAP_FLAT:
            begin
                lvl_we = 1'b1;
                lvl_wa = i_reg[ADDR_W-1:0];
                lvl_wd = min_db_reg;
            end
            ST_WIN_RD:
            begin
                lvl_re = 1'b1;
                lvl_ra = j_reg[ADDR_W-1:0];
                sm_re  = 1'b1;
            end
            ST_BLD_WR:
            begin
                sm_we = 1'b1;
            end
            default:
            begin
                lvl_we = 1'b0;
            end
        endcase
    end

    // level store, holds mapped values in place during the frame pass
    always_ff @(posedge clk)
    begin
        if (lvl_we)
            level_mem[lvl_wa] <= lvl_wd;
        if (lvl_re)
            lvl_rd_reg <= level_mem[lvl_ra];
    end

    // smoothed store, entries at or past the fill mark read as the floor
    always_ff @(posedge clk)
    begin
        if (sm_we)
            smooth_mem[sm_wa] <= sm_wd;
        if (sm_re)
            sm_rd_reg <= smooth_mem[sm_ra];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bins_reg       <= RST_BINS;
            min_db_reg     <= RST_MIN_DB;
            max_db_reg     <= RST_MAX_DB;
            weight_reg     <= RST_WEIGHT;
            peak_reg       <= FLOOR_DB;
            load_ptr_reg   <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
            y_reg          <= '0;
            p_reg          <= '0;
            frac_reg       <= '0;
            k_reg          <= '0;
            mag_zero_reg   <= 1'b0;
            db_prod_reg    <= '0;
            i_reg          <= '0;
            den_reg        <= '0;
            num_reg        <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            div_cnt_reg    <= '0;
            neg_reg        <= 1'b0;
            up_reg         <= '0;
            down_reg       <= '0;
            j_reg          <= '0;
            jlast_reg      <= '0;
            first_reg      <= 1'b0;
            best_reg       <= '0;
            prev_reg       <= '0;
            bprod_reg      <= '0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
            display_db_reg <= '0;
            bin_index_reg  <= '0;
            last_bin_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_BINS:   bins_reg   <= pwdata[12:0];
                    REG_MIN_DB: min_db_reg <= pwdata[15:0];
                    REG_MAX_DB: max_db_reg <= pwdata[15:0];
                    REG_WEIGHT: weight_reg <= pwdata[15:0];
                    default:    bins_reg   <= bins_reg;
                endcase
            end

            // the read stage refills the output register itself
            if (out_xfer && state_reg != ST_RD_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (req_type)
                        begin
                            rd_idx_reg <= rptr_eff;
                            rd_ptr_reg <= (rptr_inc >= nb) ? '0 : rptr_inc[ADDR_W-1:0];
                            state_reg  <= ST_RD_OUT;
                        end
                        else
                        begin
                            y_reg        <= magnitude << (5'd31 - msb_pos);
                            p_reg        <= msb_pos;
                            frac_reg     <= '0;
                            k_reg        <= '0;
                            mag_zero_reg <= (magnitude == 32'b0);
                            state_reg    <= ST_LOG_SQ;
                        end
                    end
                end

                // one fraction bit per squaring
                ST_LOG_SQ:
                begin
                    y_reg    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                    frac_reg <= {frac_reg[14:0], sq_t[32]};
                    k_reg    <= k_reg + 4'd1;
                    if (k_reg == 4'(LOG_ITER - 1))
                        state_reg <= ST_LOG_MUL;
                end

                ST_LOG_MUL:
                begin
                    db_prod_reg <= lg * $signed({1'b0, DB_PER_OCTAVE_Q16});
                    state_reg   <= ST_LOG_END;
                end

                ST_LOG_END:
                begin
                    if (load_inc >= nb)
                    begin
                        peak_reg  <= peak_new;
                        den_reg   <= den_w[15:0];
                        i_reg     <= '0;
                        state_reg <= (peak_new <= FLOOR_DB) ? ST_MAP_FLAT : ST_MAP_RD;
                    end
                    else
                    begin
                        peak_reg     <= peak_new;
                        load_ptr_reg <= load_inc;
                        state_reg    <= ST_IDLE;
                    end
                end

                ST_MAP_RD:
                begin
                    state_reg <= ST_MAP_MUL;
                end

                ST_MAP_MUL:
                begin
                    num_reg   <= span_w * off_w;
                    state_reg <= ST_MAP_PREP;
                end

                // rounding half away from zero: add half the divisor to the magnitude
                ST_MAP_PREP:
                begin
                    dvd_reg     <= num_mag + DIV_W'(den_reg >> 1);
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    neg_reg     <= num_reg[33];
                    state_reg   <= ST_MAP_DIV;
                end

                ST_MAP_DIV:
                begin
                    rem_reg     <= div_ge ? 16'(div_r - {1'b0, den_reg}) : div_r[15:0];
                    dvd_reg     <= {dvd_reg[DIV_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                    if (div_cnt_reg == DCNT_W'(DIV_W - 1))
                        state_reg <= ST_MAP_WR;
                end

                ST_MAP_WR, ST_MAP_FLAT:
                begin
                    if (i_inc >= nb)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_WIN_MUL;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= (state_reg == ST_MAP_FLAT) ? ST_MAP_FLAT : ST_MAP_RD;
                    end
                end

                ST_WIN_MUL:
                begin
                    up_reg    <= i_reg + up_p[CNT_W+31:32];
                    down_reg  <= down_p[CNT_W+31:32];
                    state_reg <= ST_WIN_BOUND;
                end

                ST_WIN_BOUND:
                begin
                    j_reg     <= CNT_W'(w_i1);
                    jlast_reg <= w_jlast;
                    first_reg <= 1'b1;
                    state_reg <= ST_WIN_RD;
                end

                ST_WIN_RD:
                begin
                    state_reg <= ST_WIN_CMP;
                end

                ST_WIN_CMP:
                begin
                    if (first_reg || win_val > best_reg)
                        best_reg <= win_val;
                    first_reg <= 1'b0;
                    if (j_reg == jlast_reg)
                        state_reg <= ST_BLD_MUL;
                    else
                    begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= ST_WIN_RD;
                    end
                end

                ST_BLD_MUL:
                begin
                    prev_reg  <= prev_w;
                    bprod_reg <= $signed({1'b0, weight_reg}) * diff_w;
                    state_reg <= ST_BLD_WR;
                end

                // last bin closes the frame and moves the fill mark
                ST_BLD_WR:
                begin
                    if (i_inc >= nb)
                    begin
                        if (nb > fill_reg)
                            fill_reg <= nb;
                        load_ptr_reg <= '0;
                        peak_reg     <= FLOOR_DB;
                        state_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= ST_WIN_MUL;
                    end
                end

                ST_RD_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        display_db_reg <= (CNT_W'(rd_idx_reg) < fill_reg)
                                          ? $signed(sm_rd_reg) : FLOOR_DB;
                        bin_index_reg  <= rd_idx_reg;
                        last_bin_reg   <= (CNT_W'(rd_idx_reg) == nb - CNT_W'(1));
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a load transfer never produces a result
    `SDS_ASSERT_NEXT(a_load_silent, clk, rst_n, in_xfer && !req_type, !$rose(out_valid_reg))

    // window reads stay within the span of the current bin
    `SDS_ASSERT_NOW(a_win_span, clk, rst_n, state_reg == ST_WIN_RD, (CNT_W+1)'(j_reg) <= (CNT_W+1)'(i_reg) + (CNT_W+1)'(SPAN_MAX))

    // divider remainder stays below the divisor
    `SDS_ASSERT_NOW(a_div_rem, clk, rst_n, state_reg == ST_MAP_DIV, rem_reg < den_reg)

endmodule
